>>> hdl/srpc_pkg.sv
// Shared types, constants and codes for the service RPC header parser.
package srpc_pkg;

  localparam int HEADER_BYTES      = 16;
  localparam int HDR_IDX_W         = 4;
  localparam int COUNT_W           = 16;
  localparam int ENTRY_W           = 41;
  localparam int TABLE_ENTRIES_DEF = 6;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 41;
  localparam int ERR_IDX_W         = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_BASE   = 3'd2;

  // verdict codes
  localparam logic [2:0] VERDICT_DISABLED   = 3'd0;
  localparam logic [2:0] VERDICT_MALFORMED  = 3'd1;
  localparam logic [2:0] VERDICT_DISPATCHED = 3'd2;
  localparam logic [2:0] VERDICT_NO_HANDLER = 3'd3;
  localparam logic [2:0] VERDICT_UNKNOWN    = 3'd4;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  localparam logic [31:0] LEN_BIAS           = 32'd8;
  localparam logic [7:0]  PROTO_VERSION      = 8'h01;
  localparam logic [7:0]  MSG_ERROR_CODE     = 8'h81;
  localparam logic [7:0]  RET_UNKNOWN_METHOD = 8'h03;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic [15:0] service_id;
    logic [15:0] method_id;
    logic [15:0] client_id;
    logic [15:0] session_id;
    logic [7:0]  iface_version;
    logic [7:0]  msg_type;
    logic [31:0] payload_length;
  } hdr_info_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic [2:0] entry_index;
    hdr_info_t  hdr;
  } cls_t;

endpackage

>>> hdl/srpc_capture.sv
// Header byte capture, frame byte counter and end-of-frame hold register.
module srpc_capture (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              acc,
  input  logic [7:0]                        rx_byte,
  input  logic                              last_byte,
  input  logic                              take,
  output logic                              pend,
  output logic [srpc_pkg::COUNT_W-1:0]      pend_count,
  output srpc_pkg::hdr_bytes_t              hdr
);

  logic [srpc_pkg::COUNT_W-1:0] counter;
  logic [srpc_pkg::COUNT_W-1:0] count_inc;
  logic                         in_header;

  assign in_header = (counter[srpc_pkg::COUNT_W-1:srpc_pkg::HDR_IDX_W] == '0);
  assign count_inc = (counter == '1) ? counter : counter + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      pend    <= 1'b0;
    end else begin
      if (acc) begin
        counter <= last_byte ? '0 : count_inc;
      end
      // a take and a new frame end in the same cycle leave pend set
      if (acc && last_byte) begin
        pend <= 1'b1;
      end else if (take) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last_byte) begin
      pend_count <= count_inc;
    end
    for (int i = 0; i < srpc_pkg::HEADER_BYTES; i++) begin
      if (acc && in_header && counter[srpc_pkg::HDR_IDX_W-1:0] == srpc_pkg::HDR_IDX_W'(i)) begin
        hdr[i] <= rx_byte;
      end
    end
  end

endmodule

>>> hdl/srpc_classify.sv
// Frame checks and method table lookup, all combinational.
module srpc_classify #(
  parameter int TABLE_ENTRIES = srpc_pkg::TABLE_ENTRIES_DEF
) (
  input  srpc_pkg::hdr_bytes_t                            hdr,
  input  logic [srpc_pkg::COUNT_W-1:0]                    count,
  input  logic                                            enable,
  input  logic [2:0]                                      method_count,
  input  logic [TABLE_ENTRIES-1:0][srpc_pkg::ENTRY_W-1:0] entries,
  output srpc_pkg::cls_t                                  cls
);

  logic [31:0]         lenf;
  logic                malformed;
  srpc_pkg::hdr_info_t info;
  logic                found;
  logic [2:0]          found_idx;
  logic                found_hdl;

  assign lenf = {hdr[4], hdr[5], hdr[6], hdr[7]};

  // length plus bias compared at 33 bits so it cannot wrap
  assign malformed = (count < 16'(srpc_pkg::HEADER_BYTES)) || (lenf < srpc_pkg::LEN_BIAS) ||
                     (({1'b0, lenf} + {1'b0, srpc_pkg::LEN_BIAS}) > 33'(count));

  always_comb begin
    info.service_id     = {hdr[0], hdr[1]};
    info.method_id      = {hdr[2], hdr[3]};
    info.client_id      = {hdr[8], hdr[9]};
    info.session_id     = {hdr[10], hdr[11]};
    info.iface_version  = hdr[13];
    info.msg_type       = hdr[14];
    info.payload_length = lenf - srpc_pkg::LEN_BIAS;
  end

  // first match wins: scan from the top down
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    found_hdl = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (3'(i) < method_count &&
          entries[i][39:24] == info.service_id &&
          entries[i][23:8]  == info.method_id &&
          entries[i][7:0]   == info.iface_version) begin
        found     = 1'b1;
        found_idx = 3'(i);
        found_hdl = entries[i][40];
      end
    end
  end

  always_comb begin
    cls = '0;
    if (!enable) begin
      cls.verdict = srpc_pkg::VERDICT_DISABLED;
    end else if (malformed) begin
      cls.verdict = srpc_pkg::VERDICT_MALFORMED;
    end else begin
      cls.hdr = info;
      if (found) begin
        cls.verdict     = found_hdl ? srpc_pkg::VERDICT_DISPATCHED
                                    : srpc_pkg::VERDICT_NO_HANDLER;
        cls.entry_index = found_idx;
      end else begin
        cls.verdict = srpc_pkg::VERDICT_UNKNOWN;
      end
    end
  end

endmodule

>>> hdl/srpc_emit.sv
// Result register and error frame sequencer.
module srpc_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           pend,
  input  srpc_pkg::cls_t cls,
  input  logic           out_stall,
  output logic           take,
  output logic           out_valid,
  output logic           result_kind,
  output logic [2:0]     verdict,
  output logic [2:0]     entry_index,
  output logic [15:0]    service_id,
  output logic [15:0]    method_id,
  output logic [15:0]    client_id,
  output logic [15:0]    session_id,
  output logic [7:0]     iface_version,
  output logic [7:0]     msg_type,
  output logic [31:0]    payload_length,
  output logic [7:0]     tx_byte,
  output logic           run_end
);

  logic                          out_free;
  logic                          err_active;
  logic [srpc_pkg::ERR_IDX_W-1:0] err_idx;
  logic [15:0]                   snap_svc;
  logic [15:0]                   snap_mth;
  logic [15:0]                   snap_cli;
  logic [15:0]                   snap_ses;
  logic [7:0]                    snap_ifv;
  logic [7:0]                    err_byte;

  assign out_free = !out_valid || !out_stall;
  assign take     = out_free && !err_active && pend;

  always_comb begin
    case (err_idx)
      4'd0:    err_byte = snap_svc[15:8];
      4'd1:    err_byte = snap_svc[7:0];
      4'd2:    err_byte = snap_mth[15:8];
      4'd3:    err_byte = snap_mth[7:0];
      4'd7:    err_byte = srpc_pkg::LEN_BIAS[7:0];
      4'd8:    err_byte = snap_cli[15:8];
      4'd9:    err_byte = snap_cli[7:0];
      4'd10:   err_byte = snap_ses[15:8];
      4'd11:   err_byte = snap_ses[7:0];
      4'd12:   err_byte = srpc_pkg::PROTO_VERSION;
      4'd13:   err_byte = snap_ifv;
      4'd14:   err_byte = srpc_pkg::MSG_ERROR_CODE;
      4'd15:   err_byte = srpc_pkg::RET_UNKNOWN_METHOD;
      default: err_byte = 8'h00;  // upper length bytes
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      err_active <= 1'b0;
      err_idx    <= '0;
    end else if (out_free) begin
      if (err_active) begin
        out_valid <= 1'b1;
        err_idx   <= err_idx + 1'b1;
        if (&err_idx) begin
          err_active <= 1'b0;
        end
      end else if (pend) begin
        out_valid  <= 1'b1;
        err_active <= (cls.verdict == srpc_pkg::VERDICT_UNKNOWN);
        err_idx    <= '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (err_active) begin
        result_kind    <= srpc_pkg::KIND_ERROR;
        verdict        <= srpc_pkg::VERDICT_DISABLED;
        entry_index    <= '0;
        service_id     <= '0;
        method_id      <= '0;
        client_id      <= '0;
        session_id     <= '0;
        iface_version  <= '0;
        msg_type       <= '0;
        payload_length <= '0;
        tx_byte        <= err_byte;
        run_end        <= &err_idx;
      end else if (pend) begin
        result_kind    <= srpc_pkg::KIND_VERDICT;
        verdict        <= cls.verdict;
        entry_index    <= cls.entry_index;
        service_id     <= cls.hdr.service_id;
        method_id      <= cls.hdr.method_id;
        client_id      <= cls.hdr.client_id;
        session_id     <= cls.hdr.session_id;
        iface_version  <= cls.hdr.iface_version;
        msg_type       <= cls.hdr.msg_type;
        payload_length <= cls.hdr.payload_length;
        tx_byte        <= '0;
        run_end        <= (cls.verdict != srpc_pkg::VERDICT_UNKNOWN);
        snap_svc       <= cls.hdr.service_id;
        snap_mth       <= cls.hdr.method_id;
        snap_cli       <= cls.hdr.client_id;
        snap_ses       <= cls.hdr.session_id;
        snap_ifv       <= cls.hdr.iface_version;
      end
    end
  end

endmodule

>>> hdl/service_rpc_header_parse_dispatch.sv
// Top level of the service RPC header parser and dispatcher.
//
// Input channel (in_valid/in_stall): one frame byte per request, last_byte on
// the final byte. A request is taken when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall): one verdict record per frame; an
// unknown method verdict is followed by 16 error frame bytes (result_kind 1),
// run_end marks the last result of a frame.
// Throughput: one byte per cycle while in_stall is low. A frame end is
// registered in the end-of-frame hold register and its verdict then in the
// result register; the header compare and table lookup run combinationally
// between the two. Input stalls only while a finished frame waits for the
// result register, i.e. while the receiver stalls or error bytes stream out.
// Configuration (cfg_write/cfg_index/cfg_data) must be written while idle;
// the block itself does not enforce this. Reset clears the byte counter,
// pending state, output valid and all configuration registers; the block is
// disabled until enable is written.
module service_rpc_header_parse_dispatch #(
  parameter int TABLE_ENTRIES = srpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [srpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic [2:0]                          verdict,
  output logic [2:0]                          entry_index,
  output logic [15:0]                         service_id,
  output logic [15:0]                         method_id,
  output logic [15:0]                         client_id,
  output logic [15:0]                         session_id,
  output logic [7:0]                          iface_version,
  output logic [7:0]                          msg_type,
  output logic [31:0]                         payload_length,
  output logic [7:0]                          tx_byte,
  output logic                                run_end
);

  logic                                            enable;
  logic [2:0]                                      method_count;
  logic [TABLE_ENTRIES-1:0][srpc_pkg::ENTRY_W-1:0] entries;
  logic [srpc_pkg::CFG_IDX_W-1:0]                  entry_off;

  logic                          acc;
  logic                          take;
  logic                          pend;
  logic [srpc_pkg::COUNT_W-1:0]  pend_count;
  srpc_pkg::hdr_bytes_t          hdr;
  srpc_pkg::cls_t                cls;

  assign entry_off = cfg_index - srpc_pkg::REG_ENTRY_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      method_count <= '0;
      entries      <= '0;
    end else if (cfg_write) begin
      if (cfg_index == srpc_pkg::REG_ENABLE) begin
        enable <= cfg_data[0];
      end else if (cfg_index == srpc_pkg::REG_METHOD_COUNT) begin
        method_count <= cfg_data[2:0];
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (entry_off == srpc_pkg::CFG_IDX_W'(i)) begin
            entries[i] <= cfg_data[srpc_pkg::ENTRY_W-1:0];
          end
        end
      end
    end
  end

  // a pending frame end holds the header store until it is classified
  assign in_stall = pend && !take;
  assign acc      = in_valid && !in_stall;

  srpc_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .rx_byte    (rx_byte),
    .last_byte  (last_byte),
    .take       (take),
    .pend       (pend),
    .pend_count (pend_count),
    .hdr        (hdr)
  );

  srpc_classify #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_classify (
    .hdr          (hdr),
    .count        (pend_count),
    .enable       (enable),
    .method_count (method_count),
    .entries      (entries),
    .cls          (cls)
  );

  srpc_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .pend           (pend),
    .cls            (cls),
    .out_stall      (out_stall),
    .take           (take),
    .out_valid      (out_valid),
    .result_kind    (result_kind),
    .verdict        (verdict),
    .entry_index    (entry_index),
    .service_id     (service_id),
    .method_id      (method_id),
    .client_id      (client_id),
    .session_id     (session_id),
    .iface_version  (iface_version),
    .msg_type       (msg_type),
    .payload_length (payload_length),
    .tx_byte        (tx_byte),
    .run_end        (run_end)
  );

endmodule

>>> hdl/srpc_checker.sv
// Port-level checks for the service RPC header parser, bound to the top level.
module srpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            result_kind,
  input logic [2:0]                      verdict,
  input logic [2:0]                      entry_index,
  input logic [15:0]                     service_id,
  input logic [31:0]                     payload_length,
  input logic [7:0]                      tx_byte,
  input logic                            run_end
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(verdict) &&
      $stable(tx_byte) && $stable(run_end))
    else $error("stalled result changed");

  // an unknown method verdict is followed at once by error frame bytes
  a_err_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && result_kind == srpc_pkg::KIND_VERDICT &&
      verdict == srpc_pkg::VERDICT_UNKNOWN
    |=> out_valid && result_kind == srpc_pkg::KIND_ERROR &&
      tx_byte == $past(service_id[15:8]))
    else $error("error frame did not follow unknown verdict");

  a_verdict_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == srpc_pkg::KIND_VERDICT
    |-> run_end == (verdict != srpc_pkg::VERDICT_UNKNOWN))
    else $error("run_end wrong on verdict record");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == srpc_pkg::KIND_ERROR
    |-> verdict == srpc_pkg::VERDICT_DISABLED && entry_index == 3'd0 &&
      service_id == 16'd0 && payload_length == 32'd0)
    else $error("error byte record carries header fields");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == srpc_pkg::KIND_ERROR && run_end
    |-> tx_byte == srpc_pkg::RET_UNKNOWN_METHOD)
    else $error("last error byte is not the return code");

endmodule

bind service_rpc_header_parse_dispatch srpc_checker u_srpc_checker (.*);

>>> bench/rpc_dispatch_check.sv
// Checker for the RPC header parser: predicts verdicts and error frames, compares outputs.
module rpc_dispatch_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [srpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [7:0]                        rx_byte,
  input  logic                              last_byte,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              result_kind,
  input  logic [2:0]                        verdict,
  input  logic [2:0]                        entry_index,
  input  logic [15:0]                       service_id,
  input  logic [15:0]                       method_id,
  input  logic [15:0]                       client_id,
  input  logic [15:0]                       session_id,
  input  logic [7:0]                        iface_version,
  input  logic [7:0]                        msg_type,
  input  logic [31:0]                       payload_length,
  input  logic [7:0]                        tx_byte,
  input  logic                              run_end,
  output int                                records_due,
  output int                                mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import srpc_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [2:0] verdict;
    logic [2:0] entry;
    hdr_info_t  hdr;
    logic [7:0] tx;
    logic       run_end;
  } record_t;

  record_t            due[$];
  logic [7:0]         hdr_mem [HEADER_BYTES];
  logic [COUNT_W-1:0] nbytes;
  logic               en;
  logic [2:0]         cnt;
  logic [ENTRY_W-1:0] tbl [TABLE_ENTRIES_DEF];

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic judge_frame(input logic [COUNT_W-1:0] count);
    record_t      r;
    record_t      e;
    logic [31:0]  lenf;
    logic [127:0] err_bits;
    int           hit;
    int           i;
    r = '0;
    r.kind = KIND_VERDICT;
    r.run_end = 1'b1;
    lenf = {hdr_mem[4], hdr_mem[5], hdr_mem[6], hdr_mem[7]};
    hit = -1;
    if (!en) begin
      r.verdict = VERDICT_DISABLED;
    end else if (count < HEADER_BYTES || lenf < LEN_BIAS ||
                 {1'b0, lenf} + {1'b0, LEN_BIAS} > {17'd0, count}) begin
      // 33-bit sum: a length field near 2^32 must not wrap into range
      r.verdict = VERDICT_MALFORMED;
    end else begin
      r.hdr.service_id     = {hdr_mem[0], hdr_mem[1]};
      r.hdr.method_id      = {hdr_mem[2], hdr_mem[3]};
      r.hdr.client_id      = {hdr_mem[8], hdr_mem[9]};
      r.hdr.session_id     = {hdr_mem[10], hdr_mem[11]};
      r.hdr.iface_version  = hdr_mem[13];
      r.hdr.msg_type       = hdr_mem[14];
      r.hdr.payload_length = lenf - LEN_BIAS;
      for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        if (hit < 0 && i < cnt && tbl[i][39:24] == r.hdr.service_id &&
            tbl[i][23:8] == r.hdr.method_id && tbl[i][7:0] == r.hdr.iface_version)
          hit = i;
      end
      if (hit >= 0) begin
        r.verdict = tbl[hit][40] ? VERDICT_DISPATCHED : VERDICT_NO_HANDLER;
        r.entry = 3'(hit);
      end else begin
        r.verdict = VERDICT_UNKNOWN;
        r.run_end = 1'b0;
      end
    end
    due.push_back(r);
    if (r.verdict == VERDICT_UNKNOWN) begin
      err_bits = {r.hdr.service_id, r.hdr.method_id, LEN_BIAS, r.hdr.client_id,
                  r.hdr.session_id, PROTO_VERSION, r.hdr.iface_version,
                  MSG_ERROR_CODE, RET_UNKNOWN_METHOD};
      for (i = 0; i < HEADER_BYTES; i++) begin
        e = '0;
        e.kind = KIND_ERROR;
        e.tx = err_bits[127 - 8*i -: 8];
        e.run_end = (i == HEADER_BYTES - 1);
        due.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      due.delete();
      nbytes = '0;
      en = 1'b0;
      cnt = '0;
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) tbl[i] = '0;
    end else begin
      // outputs first: anything leaving now belongs to an older frame
      if (out_valid && !out_stall) begin
        if (due.size() == 0) begin
          flag("unexpected result, tx_byte", tx_byte, '0);
        end else begin
          want = due.pop_front();
          if (result_kind !== want.kind) flag("result_kind", result_kind, want.kind);
          if (verdict !== want.verdict) flag("verdict", verdict, want.verdict);
          if (entry_index !== want.entry) flag("entry_index", entry_index, want.entry);
          if (service_id !== want.hdr.service_id)
            flag("service_id", service_id, want.hdr.service_id);
          if (method_id !== want.hdr.method_id)
            flag("method_id", method_id, want.hdr.method_id);
          if (client_id !== want.hdr.client_id)
            flag("client_id", client_id, want.hdr.client_id);
          if (session_id !== want.hdr.session_id)
            flag("session_id", session_id, want.hdr.session_id);
          if (iface_version !== want.hdr.iface_version)
            flag("iface_version", iface_version, want.hdr.iface_version);
          if (msg_type !== want.hdr.msg_type)
            flag("msg_type", msg_type, want.hdr.msg_type);
          if (payload_length !== want.hdr.payload_length)
            flag("payload_length", payload_length, want.hdr.payload_length);
          if (tx_byte !== want.tx) flag("tx_byte", tx_byte, want.tx);
          if (run_end !== want.run_end) flag("run_end", run_end, want.run_end);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLE:       en = cfg_data[0];
          REG_METHOD_COUNT: cnt = cfg_data[2:0];
          default:          tbl[cfg_index - REG_ENTRY_BASE] = cfg_data;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (nbytes < HEADER_BYTES) hdr_mem[nbytes[HDR_IDX_W-1:0]] = rx_byte;
        if (nbytes != '1) nbytes++;
        if (last_byte) begin
          judge_frame(nbytes);
          nbytes = '0;
        end
      end
    end
    records_due = due.size();
  end

endmodule

>>> bench/tb.sv
// Testbench top for the RPC header parser: clock, reset, frame stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srpc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  result_kind;
  logic [2:0]            verdict;
  logic [2:0]            entry_index;
  logic [15:0]           service_id;
  logic [15:0]           method_id;
  logic [15:0]           client_id;
  logic [15:0]           session_id;
  logic [7:0]            iface_version;
  logic [7:0]            msg_type;
  logic [31:0]           payload_length;
  logic [7:0]            tx_byte;
  logic                  run_end;
  int                    records_due;
  int                    mismatches;

  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_count = 0;
  logic [ENTRY_W-1:0]    tbl_img [TABLE_ENTRIES_DEF];

  service_rpc_header_parse_dispatch u_dut (.*);
  rpc_dispatch_check u_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_entry(input int j, input logic [ENTRY_W-1:0] e);
    tbl_img[j] = e;
    write_reg(REG_ENTRY_BASE + CFG_IDX_W'(j), e);
  endtask

  // hold off until every predicted result is out, then let the pipe settle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (records_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    last_byte <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input logic [15:0] svc, input logic [15:0] mth,
                            input logic [7:0] ifv, input logic [31:0] lenf, input int total);
    logic [127:0] h;
    logic [7:0]   b;
    int           k;
    h = {svc, mth, lenf, 16'($urandom), 16'($urandom), 8'($urandom), ifv,
         8'($urandom), 8'($urandom)};
    for (k = 0; k < total; k++) begin
      if (k < HEADER_BYTES) b = h[127 - 8*k -: 8];
      else b = 8'($urandom);
      send_byte(b, k == total - 1);
    end
  endtask

  task automatic entry_frame(input int j, input logic [31:0] lenf, input int total);
    send_frame(tbl_img[j][39:24], tbl_img[j][23:8], tbl_img[j][7:0], lenf, total);
  endtask

  task automatic random_config();
    int                 j;
    logic [ENTRY_W-1:0] e;
    write_reg(REG_ENABLE, CFG_DATA_W'($urandom_range(0, 7) != 0));
    write_reg(REG_METHOD_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
    for (j = 0; j < TABLE_ENTRIES_DEF; j++) begin
      e = ENTRY_W'({$urandom, $urandom});
      // twin of the previous entry, other handler bit: first match must win
      if (j > 0 && $urandom_range(0, 3) == 0) begin
        e = tbl_img[j-1];
        e[40] = ~e[40];
      end
      set_entry(j, e);
    end
  endtask

  // mostly well-formed frames aimed at table entries, some near misses and broken ones
  task automatic random_frame();
    int          j;
    int          pick;
    int          total;
    logic [15:0] s;
    logic [15:0] m;
    logic [7:0]  v;
    logic [31:0] lf;
    j = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
    s = tbl_img[j][39:24];
    m = tbl_img[j][23:8];
    v = tbl_img[j][7:0];
    pick = $urandom_range(0, 99);
    if (pick < 10) s ^= 16'(1) << $urandom_range(0, 15);
    else if (pick < 20) m ^= 16'(1) << $urandom_range(0, 15);
    else if (pick < 28) v ^= 8'(1) << $urandom_range(0, 7);
    else if (pick < 33) begin
      s = 16'($urandom);
      m = 16'($urandom);
      v = 8'($urandom);
    end
    total = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(16, 36);
    lf = $urandom_range(8, total - 8);
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: total = $urandom_range(1, 15);
        1: lf = $urandom_range(0, 7);
        2: lf = total - 7 + $urandom_range(0, 40);
        default: lf = $urandom;
      endcase
    end
    send_frame(s, m, v, lf, total);
  endtask

  initial begin
    int ph;
    int f;
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) tbl_img[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // out of reset the block is disabled
    send_frame(16'h1234, 16'h0001, 8'h01, 32'd8, 16);
    settle();
    write_reg(REG_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_METHOD_COUNT, CFG_DATA_W'(6));
    set_entry(0, {1'b1, 16'h1234, 16'h0001, 8'h01});
    set_entry(1, {1'b0, 16'h1234, 16'h0002, 8'h01});
    set_entry(2, {1'b1, 16'h1234, 16'h0002, 8'h01});
    set_entry(3, {1'b1, 16'hFFFF, 16'hFFFF, 8'hFF});
    set_entry(4, {1'b0, 16'h0000, 16'h0000, 8'h00});
    set_entry(5, {1'b1, 16'hBEEF, 16'h8001, 8'h7F});

    entry_frame(0, 32'd8, 1);             // single byte frame
    entry_frame(0, 32'd8, 15);            // one short of a header
    entry_frame(0, 32'd7, 16);            // length field under bias
    entry_frame(0, 32'hFFFF_FFF8, 16);    // length + 8 wraps to zero in 32 bits
    entry_frame(0, 32'hFFFF_FFFF, 16);
    entry_frame(0, 32'd17, 24);           // one byte past the frame
    entry_frame(0, 32'd16, 24);           // exact fit
    entry_frame(1, 32'd8, 16);            // no handler, shadows its twin
    entry_frame(3, 32'd8, 16);
    entry_frame(4, 32'd8, 16);
    entry_frame(5, 32'd12, 20);
    send_frame(16'h1234, 16'h0001, 8'h02, 32'd8, 16);  // version mismatch
    settle();
    write_reg(REG_METHOD_COUNT, CFG_DATA_W'(7));
    entry_frame(5, 32'd8, 16);
    send_frame(16'hBEEF, 16'h8002, 8'h7F, 32'd8, 18);
    settle();
    write_reg(REG_METHOD_COUNT, CFG_DATA_W'(0));
    entry_frame(0, 32'd8, 16);
    settle();
    write_reg(REG_ENABLE, CFG_DATA_W'(0));
    entry_frame(0, 32'd8, 16);
    settle();
    write_reg(REG_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_METHOD_COUNT, CFG_DATA_W'(6));
    // byte count saturates at 65535
    entry_frame(0, 32'd65528, 65600);
    entry_frame(0, 32'd65527, 65600);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      settle();
      random_config();
      for (f = 0; f < 16; f++) begin
        random_frame();
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
